/* rtl/bbt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bbt_pkg;

	localparam int OPEN_W = 7;

	typedef logic [1:0] lex_mode_t;
	localparam lex_mode_t MODE_NORMAL  = 2'd0;
	localparam lex_mode_t MODE_STRING  = 2'd1;
	localparam lex_mode_t MODE_COMMENT = 2'd2;

	typedef logic [1:0] closer_t;
	localparam closer_t CL_PAREN = 2'd0;
	localparam closer_t CL_BRACK = 2'd1;
	localparam closer_t CL_BRACE = 2'd2;

	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       line_end;
	} in_t;

	typedef struct packed {
		logic [OPEN_W-1:0] open_count;
		logic              balanced;
		lex_mode_t         lex_mode;
		logic              overflowed;
	} out_t;

endpackage

`default_nettype wire

/* rtl/bbt_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module bbt_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* rtl/bracket_balance_tracker_top.sv */
// channel   | valid     | ready     | payload
// ----------+-----------+-----------+----------------------------------------------
// input     | in_valid  | in_ready  | in_data  (char_byte, line_end)
// output    | out_valid | out_ready | out_data (open_count, balanced, lex_mode,
//           |           |           |           overflowed)
//
// one byte per cycle while out_ready is high; the result is registered
// the stack top sits in a register, the rest in a ram whose registered read is
// issued ahead of use for the entry just below the next top
// reset clears level, lexer state and overflow; ram contents are left as is
// an output stall holds the input register, ready is low only when it is full too
`timescale 1ns / 1ps
`default_nettype none

module bracket_balance_tracker_top import bbt_pkg::*; #(
	parameter int STACK_DEPTH = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire in_t  in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_t      out_data
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int LW = $clog2(STACK_DEPTH + 1);
	localparam logic [LW-1:0] DEPTH_L = LW'(STACK_DEPTH);
	localparam logic [LW-1:0] ONE_L   = LW'(1);
	localparam logic [LW-1:0] TWO_L   = LW'(2);

	logic            valid_s1;
	in_t             in_s1;
	logic            out_valid_q;
	out_t            out_q;

	logic [LW-1:0]   level_q;
	closer_t         top_q;
	lex_mode_t       mode_q;
	logic            quote_q;
	logic            esc_q;
	logic            ovf_q;
	logic            byp_q;
	closer_t         byp_data_q;

	logic            adv;
	logic            proc;
	closer_t         ram_rdata;
	closer_t         sec;
	logic            push_req;
	logic            pop_req;
	closer_t         push_code;
	closer_t         pop_code;
	logic [LW-1:0]   level_d;
	closer_t         top_d;
	lex_mode_t       mode_d;
	logic            quote_d;
	logic            esc_d;
	logic            ovf_d;
	logic            ram_we;
	logic [LW-1:0]   level_m1;
	logic [LW-1:0]   level_nx;
	logic [LW-1:0]   rd_level;
	logic [7:0]      ch;
	logic [7:0]      quote_ch;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || adv;
	assign proc     = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			in_s1 <= in_data;
		end
	end

	// entry below the top: fresh write of the previous cycle wins over the ram
	assign sec = byp_q ? byp_data_q : ram_rdata;
	assign ch  = in_s1.char_byte;
	assign quote_ch = quote_q ? CH_DQUOTE : CH_SQUOTE;

	always_comb begin
		push_req  = 1'b0;
		pop_req   = 1'b0;
		push_code = CL_PAREN;
		pop_code  = CL_PAREN;
		mode_d    = mode_q;
		quote_d   = quote_q;
		esc_d     = esc_q;
		case (mode_q)
			MODE_STRING: begin
				if (esc_q) begin
					esc_d = 1'b0;
				end else if (ch == quote_ch) begin
					mode_d = MODE_NORMAL;
				end else if (ch == CH_BSLASH) begin
					esc_d = 1'b1;
				end
			end
			MODE_COMMENT: begin
			end
			default: begin
				case (ch)
					CH_HASH:   mode_d = MODE_COMMENT;
					CH_LPAREN: begin push_req = 1'b1; push_code = CL_PAREN; end
					CH_LBRACK: begin push_req = 1'b1; push_code = CL_BRACK; end
					CH_LBRACE: begin push_req = 1'b1; push_code = CL_BRACE; end
					CH_RPAREN: begin pop_req = 1'b1; pop_code = CL_PAREN; end
					CH_RBRACK: begin pop_req = 1'b1; pop_code = CL_BRACK; end
					CH_RBRACE: begin pop_req = 1'b1; pop_code = CL_BRACE; end
					CH_SQUOTE: begin
						mode_d  = MODE_STRING;
						quote_d = 1'b0;
						esc_d   = 1'b0;
					end
					CH_DQUOTE: begin
						mode_d  = MODE_STRING;
						quote_d = 1'b1;
						esc_d   = 1'b0;
					end
					default: begin
					end
				endcase
			end
		endcase
	end

	assign level_m1 = level_q - ONE_L;

	always_comb begin
		level_d = level_q;
		top_d   = top_q;
		ovf_d   = ovf_q;
		ram_we  = 1'b0;
		if (push_req) begin
			if (level_q == DEPTH_L) begin
				ovf_d = 1'b1;
			end else begin
				level_d = level_q + ONE_L;
				top_d   = push_code;
				ram_we  = proc && (level_q != '0);
			end
		end else if (pop_req) begin
			if (level_q != '0 && top_q == pop_code) begin
				level_d = level_m1;
				top_d   = sec;
			end
		end
	end

	assign level_nx = proc ? level_d : level_q;
	assign rd_level = level_nx - TWO_L;

	bbt_ram #(
		.WIDTH ($bits(closer_t)),
		.DEPTH (STACK_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (level_m1[AW-1:0]),
		.wdata (top_q),
		.raddr (rd_level[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			mode_q  <= MODE_NORMAL;
			quote_q <= 1'b0;
			esc_q   <= 1'b0;
			ovf_q   <= 1'b0;
			byp_q   <= 1'b0;
		end else begin
			byp_q <= ram_we;
			if (proc) begin
				level_q <= level_d;
				ovf_q   <= ovf_d;
				// string, escape and comment state end with the line
				if (in_s1.line_end) begin
					mode_q  <= MODE_NORMAL;
					quote_q <= 1'b0;
					esc_q   <= 1'b0;
				end else begin
					mode_q  <= mode_d;
					quote_q <= quote_d;
					esc_q   <= esc_d;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= top_q;
		if (proc) begin
			top_q <= top_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			out_q.open_count <= OPEN_W'(level_d);
			out_q.balanced   <= (level_d == '0);
			out_q.lex_mode   <= mode_d;
			out_q.overflowed <= ovf_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

/* rtl/bbt_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module bbt_checker import bbt_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire out_t out_data
);

	logic              ovf_seen_q;
	logic              have_prev_q;
	logic [OPEN_W-1:0] prev_cnt_q;
	logic [OPEN_W-1:0] cnt_step;
	logic              out_xfer;

	assign out_xfer = out_valid && out_ready;
	assign cnt_step = out_data.open_count - prev_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_seen_q  <= 1'b0;
			have_prev_q <= 1'b0;
			prev_cnt_q  <= '0;
		end else if (out_xfer) begin
			ovf_seen_q  <= ovf_seen_q || out_data.overflowed;
			have_prev_q <= 1'b1;
			prev_cnt_q  <= out_data.open_count;
		end
	end

	a_balanced_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.balanced == (out_data.open_count == '0)))
		else $error("balanced flag disagrees with open count");

	a_mode_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.lex_mode != 2'd3))
		else $error("lexer mode out of range");

	a_overflow_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ovf_seen_q |-> out_data.overflowed)
		else $error("overflow flag cleared after being set");

	// each byte moves the open count by at most one bracket
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && have_prev_q |->
			(cnt_step == '0 || cnt_step == OPEN_W'(1) || cnt_step == '1))
		else $error("open count jumped by more than one");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed or dropped");

endmodule

bind bracket_balance_tracker_top bbt_checker u_bbt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire

/* tb/tb_bracket_balance_tracker_top.sv */
`timescale 1ns / 1ps

module tb_bracket_balance_tracker_top;
	import bbt_pkg::*;

	localparam int STACK_DEPTH = 64;
	localparam int N_ITEMS     = 1450;
	localparam int N_DIRECTED  = 24;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 60;

	typedef struct packed {
		logic [7:0] ch;
		logic       eol;
		logic       fixed;
		out_t       want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t  in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;

	// bracket tracker state as the block should hold it
	closer_t   closer_stk [STACK_DEPTH];
	int        nest_lvl;
	lex_mode_t cur_mode;
	logic      dq_string;
	logic      esc_pending;
	logic      ovf_seen;

	out_t expected_status [$];
	int   errors;
	int   sent_cnt;
	int   cycle_cnt;
	int   hold_left;
	bit   hold_done;
	bit   steady;

	logic [7:0] opener_chars [3];
	logic [7:0] closer_chars [3];
	dir_row_t   dir_rows [N_DIRECTED];

	bracket_balance_tracker_top #(
		.STACK_DEPTH(STACK_DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic out_t mk_status(input int cnt, input lex_mode_t m);
		out_t r;
		r.open_count = cnt[OPEN_W-1:0];
		r.balanced   = (cnt == 0);
		r.lex_mode   = m;
		r.overflowed = 1'b0;
		return r;
	endfunction

	function automatic out_t track_byte(input logic [7:0] ch, input logic eol);
		out_t    r;
		closer_t code;
		case (cur_mode)
			MODE_STRING: begin
				if (esc_pending)
					esc_pending = 1'b0;
				else if (ch == (dq_string ? CH_DQUOTE : CH_SQUOTE))
					cur_mode = MODE_NORMAL;
				else if (ch == CH_BSLASH)
					esc_pending = 1'b1;
			end
			MODE_COMMENT: ;
			default: begin
				case (ch)
					CH_HASH: cur_mode = MODE_COMMENT;
					CH_LPAREN, CH_LBRACK, CH_LBRACE: begin
						code = (ch == CH_LPAREN) ? CL_PAREN :
							(ch == CH_LBRACK) ? CL_BRACK : CL_BRACE;
						if (nest_lvl >= STACK_DEPTH) begin
							ovf_seen = 1'b1;
						end else begin
							closer_stk[nest_lvl] = code;
							nest_lvl++;
						end
					end
					CH_RPAREN, CH_RBRACK, CH_RBRACE: begin
						code = (ch == CH_RPAREN) ? CL_PAREN :
							(ch == CH_RBRACK) ? CL_BRACK : CL_BRACE;
						if (nest_lvl != 0 && closer_stk[nest_lvl-1] == code)
							nest_lvl--;
					end
					CH_SQUOTE, CH_DQUOTE: begin
						cur_mode    = MODE_STRING;
						dq_string   = (ch == CH_DQUOTE);
						esc_pending = 1'b0;
					end
					default: ;
				endcase
			end
		endcase
		r.open_count = nest_lvl[OPEN_W-1:0];
		r.balanced   = (nest_lvl == 0);
		r.lex_mode   = cur_mode;
		r.overflowed = ovf_seen;
		// string, escape and comment state do not survive the line end
		if (eol) begin
			cur_mode    = MODE_NORMAL;
			dq_string   = 1'b0;
			esc_pending = 1'b0;
		end
		return r;
	endfunction

	task automatic send_byte(input logic [7:0] ch, input logic eol, input logic fixed,
			input out_t want);
		out_t predicted;
		while (!steady && $urandom_range(99) < 36) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{char_byte: ch, line_end: eol};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predicted = track_byte(ch, eol);
		expected_status.push_back(fixed ? want : predicted);
		sent_cnt++;
	endtask

	task automatic check_field(input string name, input logic [6:0] e, input logic [6:0] a);
		if (e !== a) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
			errors++;
		end
	endtask

	// result checker
	always @(posedge clk) begin : chk
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_status.size() == 0) begin
				$display("%0t: unexpected transfer, expected none, actual %p",
					$time, out_data);
				errors++;
			end else begin
				want = expected_status.pop_front();
				check_field("open_count", 7'(want.open_count), 7'(out_data.open_count));
				check_field("balanced", 7'(want.balanced), 7'(out_data.balanced));
				check_field("lex_mode", 7'(want.lex_mode), 7'(out_data.lex_mode));
				check_field("overflowed", 7'(want.overflowed), 7'(out_data.overflowed));
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver: random stalls, one long hold-off so the input side backs up
	initial begin
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (!hold_done && sent_cnt >= 300) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= steady || ($urandom_range(99) >= 36);
			end
		end
	end

	initial begin
		int         k;
		int         line_len;
		int         roll;
		bit         noisy;
		bit         deep_done;
		logic [7:0] ch;

		errors      = 0;
		sent_cnt    = 0;
		cycle_cnt   = 0;
		hold_left   = 0;
		hold_done   = 1'b0;
		steady      = 1'b0;
		deep_done   = 1'b0;
		nest_lvl    = 0;
		cur_mode    = MODE_NORMAL;
		dq_string   = 1'b0;
		esc_pending = 1'b0;
		ovf_seen    = 1'b0;
		opener_chars = '{CH_LPAREN, CH_LBRACK, CH_LBRACE};
		closer_chars = '{CH_RPAREN, CH_RBRACK, CH_RBRACE};

		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		in_data  <= '0;

		dir_rows = '{
			'{8'h00,     1'b0, 1'b1, mk_status(0, MODE_NORMAL)},
			'{8'hFF,     1'b1, 1'b1, mk_status(0, MODE_NORMAL)},
			'{CH_RPAREN, 1'b0, 1'b1, mk_status(0, MODE_NORMAL)},
			'{CH_LPAREN, 1'b0, 1'b1, mk_status(1, MODE_NORMAL)},
			'{CH_LBRACK, 1'b0, 1'b1, mk_status(2, MODE_NORMAL)},
			'{CH_LBRACE, 1'b0, 1'b1, mk_status(3, MODE_NORMAL)},
			'{CH_RPAREN, 1'b0, 1'b1, mk_status(3, MODE_NORMAL)},
			'{CH_RBRACE, 1'b0, 1'b1, mk_status(2, MODE_NORMAL)},
			'{CH_RBRACK, 1'b0, 1'b1, mk_status(1, MODE_NORMAL)},
			'{CH_DQUOTE, 1'b0, 1'b1, mk_status(1, MODE_STRING)},
			'{CH_LPAREN, 1'b0, 1'b0, '0},
			'{CH_BSLASH, 1'b0, 1'b0, '0},
			'{CH_DQUOTE, 1'b0, 1'b0, '0},
			'{CH_SQUOTE, 1'b0, 1'b0, '0},
			'{CH_DQUOTE, 1'b0, 1'b1, mk_status(1, MODE_NORMAL)},
			'{CH_SQUOTE, 1'b0, 1'b1, mk_status(1, MODE_STRING)},
			'{CH_BSLASH, 1'b1, 1'b1, mk_status(1, MODE_STRING)},
			'{CH_SQUOTE, 1'b0, 1'b0, '0},
			'{CH_SQUOTE, 1'b1, 1'b0, '0},
			'{CH_HASH,   1'b0, 1'b1, mk_status(1, MODE_COMMENT)},
			'{CH_RPAREN, 1'b0, 1'b1, mk_status(1, MODE_COMMENT)},
			'{8'h78,     1'b1, 1'b1, mk_status(1, MODE_COMMENT)},
			'{CH_RPAREN, 1'b0, 1'b1, mk_status(0, MODE_NORMAL)},
			'{CH_SQUOTE, 1'b1, 1'b1, mk_status(0, MODE_STRING)}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < N_DIRECTED; k++)
			send_byte(dir_rows[k].ch, dir_rows[k].eol, dir_rows[k].fixed, dir_rows[k].want);

		while (sent_cnt < N_ITEMS) begin
			steady = (sent_cnt >= 600 && sent_cnt < 800);
			// fill past the top, then unwind with matching closers
			if (!deep_done && sent_cnt >= 900) begin
				deep_done = 1'b1;
				for (k = 0; k < STACK_DEPTH + 6; k++)
					send_byte(opener_chars[$urandom_range(2)], (k % 16) == 15, 1'b0, '0);
				while (nest_lvl != 0)
					send_byte(closer_chars[closer_stk[nest_lvl-1]],
						$urandom_range(15) == 0, 1'b0, '0);
			end
			line_len = $urandom_range(24, 1);
			noisy    = $urandom_range(99) < 25;
			for (k = 0; k < line_len; k++) begin
				roll = $urandom_range(99);
				if (noisy)
					ch = $urandom_range(255);
				else if (roll < 22 && nest_lvl < 12)
					ch = opener_chars[$urandom_range(2)];
				else if (roll < 45 && nest_lvl != 0)
					ch = closer_chars[closer_stk[nest_lvl-1]];
				else if (roll < 52)
					ch = closer_chars[$urandom_range(2)];
				else if (roll < 62)
					ch = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
				else if (roll < 68)
					ch = CH_BSLASH;
				else if (roll < 71)
					ch = CH_HASH;
				else
					ch = $urandom_range(126, 32);
				send_byte(ch, k == line_len - 1 || (noisy && $urandom_range(9) == 0),
					1'b0, '0);
			end
		end
		steady = 1'b0;
		in_valid <= 1'b0;

		while (expected_status.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* sim.f */
rtl/bbt_pkg.sv
rtl/bbt_ram.sv
rtl/bracket_balance_tracker_top.sv
rtl/bbt_checker.sv
tb/tb_bracket_balance_tracker_top.sv
